FILE: src/lcb_pkg.sv
// Shared types and constants for the byte-budget LRU cache.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package lcb_pkg;

    localparam int TOTAL_W = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EVICT_FLOOR = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [31:0] item_bytes;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [4:0]         evicted;
        logic [TOTAL_W-1:0] bytes_held;
        logic [4:0]         entries_held;
        logic [31:0]        hit_total;
        logic [31:0]        miss_total;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LK_CMP,
        ST_UNLINK,
        ST_LINK,
        ST_RG_CHK,
        ST_EVB_DO,
        ST_EVB_CHK,
        ST_RG_FULL,
        ST_EVF_DO,
        ST_ALLOC,
        ST_POP,
        ST_INSERT,
        ST_FIN
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LK_START,
        OP_LK_STEP,
        OP_HIT,
        OP_MISS,
        OP_UNLINK,
        OP_LINK_FRONT,
        OP_ADD,
        OP_EV_RD,
        OP_EV_DO,
        OP_ALLOC_RD,
        OP_ALLOC_FILL,
        OP_POP,
        OP_INSERT,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic used_zero;
        logic tag_match;
        logic last_entry;
        logic cur_is_front;
        logic evict_trig;
        logic keep_evict;
        logic full;
        logic have_free;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/lcb_req_if.sv
// Request channel interface: valid/ready handshake with one request item.
// Depends on lcb_pkg for the payload type.
`default_nettype none

interface lcb_req_if
    import lcb_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/lcb_rsp_if.sv
// Response channel interface: valid/ready handshake with one result item.
// Depends on lcb_pkg for the payload type.
`default_nettype none

interface lcb_rsp_if
    import lcb_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/lcb_ctrl.sv
// Sequencing FSM of the cache: issues at most one datapath command per cycle.
// Depends on lcb_pkg for the state, command and status types.
`default_nettype none

module lcb_ctrl
    import lcb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.mode)
                begin
                    cmd.op     = OP_ADD;
                    state_next = ST_RG_CHK;
                end
                else if (stat.used_zero)
                begin
                    cmd.op     = OP_MISS;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_LK_START;
                    state_next = ST_LK_CMP;
                end
            end
            ST_LK_CMP:
            begin
                if (stat.tag_match)
                begin
                    cmd.op     = OP_HIT;
                    state_next = stat.cur_is_front ? ST_FIN : ST_UNLINK;
                end
                else if (stat.last_entry)
                begin
                    cmd.op     = OP_MISS;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_LK_STEP;
                    state_next = ST_LK_CMP;
                end
            end
            ST_UNLINK:
            begin
                cmd.op     = OP_UNLINK;
                state_next = ST_LINK;
            end
            ST_LINK:
            begin
                cmd.op     = OP_LINK_FRONT;
                state_next = ST_FIN;
            end
            ST_RG_CHK:
            begin
                if (stat.evict_trig)
                begin
                    cmd.op     = OP_EV_RD;
                    state_next = ST_EVB_DO;
                end
                else
                begin
                    state_next = ST_RG_FULL;
                end
            end
            ST_EVB_DO:
            begin
                cmd.op     = OP_EV_DO;
                state_next = ST_EVB_CHK;
            end
            ST_EVB_CHK:
            begin
                if (stat.keep_evict)
                begin
                    cmd.op     = OP_EV_RD;
                    state_next = ST_EVB_DO;
                end
                else
                begin
                    state_next = ST_RG_FULL;
                end
            end
            ST_RG_FULL:
            begin
                if (stat.full)
                begin
                    cmd.op     = OP_EV_RD;
                    state_next = ST_EVF_DO;
                end
                else
                begin
                    state_next = ST_ALLOC;
                end
            end
            ST_EVF_DO:
            begin
                cmd.op     = OP_EV_DO;
                state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                if (stat.have_free)
                begin
                    cmd.op     = OP_ALLOC_RD;
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.op     = OP_ALLOC_FILL;
                    state_next = ST_INSERT;
                end
            end
            ST_POP:
            begin
                cmd.op     = OP_POP;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.op     = OP_INSERT;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/lcb_dp.sv
// Datapath of the cache: entry memories, list pointers, totals, counters and
// the output register. Depends on lcb_pkg; driven by commands from lcb_ctrl.
`default_nettype none

module lcb_dp
    import lcb_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire req_t                  req_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rsp_t                       out_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Entry memories, one read address shared by all four, read data registered.
    logic [TAG_BITS-1:0] tag_mem  [SLOTS];
    logic [31:0]         size_mem [SLOTS];
    logic [SLOT_W-1:0]   next_mem [SLOTS];
    logic [SLOT_W-1:0]   prev_mem [SLOTS];

    logic [TAG_BITS-1:0] tag_q;
    logic [31:0]         size_q;
    logic [SLOT_W-1:0]   next_q;
    logic [SLOT_W-1:0]   prev_q;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;

    logic                tag_we;
    logic                size_we;
    logic                next_we;
    logic [SLOT_W-1:0]   next_waddr;
    logic [SLOT_W-1:0]   next_wdata;
    logic                prev_we;
    logic [SLOT_W-1:0]   prev_waddr;
    logic [SLOT_W-1:0]   prev_wdata;

    logic [31:0]         limit_reg;
    logic [31:0]         floor_reg;

    logic                mode_reg;
    logic [TAG_BITS-1:0] key_reg;
    logic [31:0]         bytes_reg;
    logic                hit_reg;
    logic [CNT_W-1:0]    evict_cnt_reg;

    logic [SLOT_W-1:0]   front_reg;
    logic [SLOT_W-1:0]   back_reg;
    logic [SLOT_W-1:0]   free_head_reg;
    logic [SLOT_W-1:0]   cur_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [31:0]         hit_cnt_reg;
    logic [31:0]         miss_cnt_reg;

    logic                out_valid_reg;
    rsp_t                out_data_reg;

    logic [TOTAL_W:0]    sum_wide;
    logic [TOTAL_W-1:0]  total_add;
    logic [TOTAL_W-1:0]  total_sub;

    assign sum_wide  = {1'b0, total_reg} + {{(TOTAL_W - 31){1'b0}}, bytes_reg};
    assign total_add = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
    assign total_sub = (total_reg > {{(TOTAL_W - 32){1'b0}}, size_q})
                       ? total_reg - {{(TOTAL_W - 32){1'b0}}, size_q}
                       : '0;

    assign stat.mode         = mode_reg;
    assign stat.used_zero    = (used_reg == '0);
    assign stat.tag_match    = (tag_q == key_reg);
    assign stat.last_entry   = ((idx_reg + CNT_W'(1)) == used_reg);
    assign stat.cur_is_front = (cur_reg == front_reg);
    assign stat.evict_trig   = (limit_reg != '0)
                               && ({{(TOTAL_W - 32){1'b0}}, limit_reg} <= total_reg)
                               && (used_reg != '0);
    assign stat.keep_evict   = (used_reg != '0)
                               && ({{(TOTAL_W - 32){1'b0}}, floor_reg} < total_reg);
    assign stat.full         = (used_reg == CNT_W'(SLOTS));
    assign stat.have_free    = (used_reg < fill_reg);
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Read address and memory write controls for the current command.
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        tag_we     = 1'b0;
        size_we    = 1'b0;
        next_we    = 1'b0;
        next_waddr = cur_reg;
        next_wdata = front_reg;
        prev_we    = 1'b0;
        prev_waddr = front_reg;
        prev_wdata = cur_reg;
        case (cmd.op)
            OP_LK_START:
            begin
                rd_en   = 1'b1;
                rd_addr = front_reg;
            end
            OP_LK_STEP:
            begin
                rd_en   = 1'b1;
                rd_addr = next_q;
            end
            OP_UNLINK:
            begin
                if (cur_reg != back_reg)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_q;
                    prev_wdata = prev_q;
                    next_we    = 1'b1;
                    next_waddr = prev_q;
                    next_wdata = next_q;
                end
            end
            OP_LINK_FRONT:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            OP_EV_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = back_reg;
            end
            OP_EV_DO:
            begin
                // The evicted slot goes onto the free list through its next link.
                next_we    = 1'b1;
                next_waddr = back_reg;
                next_wdata = free_head_reg;
            end
            OP_ALLOC_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = free_head_reg;
            end
            OP_INSERT:
            begin
                tag_we  = 1'b1;
                size_we = 1'b1;
                next_we = 1'b1;
                prev_we = (used_reg != '0);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[cur_reg] <= key_reg;
        end
        if (size_we)
        begin
            size_mem[cur_reg] <= bytes_reg;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (rd_en)
        begin
            tag_q  <= tag_mem[rd_addr];
            size_q <= size_mem[rd_addr];
            next_q <= next_mem[rd_addr];
            prev_q <= prev_mem[rd_addr];
        end
    end

    // Captured request, lookup cursor and index, and result payload.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                mode_reg  <= req_data.mode;
                key_reg   <= req_data.key[TAG_BITS-1:0];
                bytes_reg <= req_data.item_bytes;
            end
            OP_LK_START:
            begin
                cur_reg <= front_reg;
                idx_reg <= '0;
            end
            OP_LK_STEP:
            begin
                cur_reg <= next_q;
                idx_reg <= idx_reg + CNT_W'(1);
            end
            OP_ALLOC_FILL:
            begin
                cur_reg <= fill_reg[SLOT_W-1:0];
            end
            OP_POP:
            begin
                cur_reg <= free_head_reg;
            end
            OP_PUBLISH:
            begin
                out_data_reg.hit          <= hit_reg;
                out_data_reg.evicted      <= 5'(evict_cnt_reg);
                out_data_reg.bytes_held   <= total_reg;
                out_data_reg.entries_held <= 5'(used_reg);
                out_data_reg.hit_total    <= hit_cnt_reg;
                out_data_reg.miss_total   <= miss_cnt_reg;
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    // Configuration registers, cache control state, totals and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            floor_reg     <= '0;
            hit_reg       <= 1'b0;
            evict_cnt_reg <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            free_head_reg <= '0;
            used_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BYTE_LIMIT:  limit_reg <= cfg_data;
                    REG_EVICT_FLOOR: floor_reg <= cfg_data;
                    default:         limit_reg <= limit_reg;
                endcase
            end

            if (out_valid_reg && out_ready && (cmd.op != OP_PUBLISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                OP_CAPTURE:
                begin
                    hit_reg       <= 1'b0;
                    evict_cnt_reg <= '0;
                end
                OP_HIT:
                begin
                    hit_reg     <= 1'b1;
                    hit_cnt_reg <= hit_cnt_reg + 32'd1;
                end
                OP_MISS:
                begin
                    miss_cnt_reg <= miss_cnt_reg + 32'd1;
                end
                OP_UNLINK:
                begin
                    if (cur_reg == back_reg)
                    begin
                        back_reg <= prev_q;
                    end
                end
                OP_LINK_FRONT:
                begin
                    front_reg <= cur_reg;
                end
                OP_ADD:
                begin
                    total_reg <= total_add;
                end
                OP_EV_DO:
                begin
                    total_reg     <= total_sub;
                    if (used_reg > CNT_W'(1))
                    begin
                        back_reg <= prev_q;
                    end
                    free_head_reg <= back_reg;
                    used_reg      <= used_reg - CNT_W'(1);
                    evict_cnt_reg <= evict_cnt_reg + CNT_W'(1);
                end
                OP_ALLOC_FILL:
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
                OP_POP:
                begin
                    free_head_reg <= next_q;
                end
                OP_INSERT:
                begin
                    if (used_reg == '0)
                    begin
                        back_reg <= cur_reg;
                    end
                    front_reg <= cur_reg;
                    used_reg  <= used_reg + CNT_W'(1);
                end
                OP_PUBLISH:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/lru_cache_byte_budget.sv
// Top level of the byte-budget LRU cache: controller plus datapath.
// Depends on lcb_pkg, lcb_req_if, lcb_rsp_if, lcb_ctrl and lcb_dp.
//
// Usage: requests arrive on req (mode, key, item_bytes) with a valid/ready
// handshake; each request yields exactly one result on rsp. A lookup walks
// the recency list from the front, one entry per cycle, then moves a hit
// that is not yet at the front there with an unlink step and a link step.
// A register adds the size to the byte total and evicts from the back with
// a read step and an evict step per evicted entry, then allocates and
// inserts a slot. One request is in work at a time; the result sits in an
// output register, so a new request is taken while a finished result waits
// for the receiver. If the receiver stalls, the next result waits in the
// last step until the output register frees up. Reset empties the cache and
// clears totals, counters and both configuration registers; no clearing
// pass is needed.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`default_nettype none

module lru_cache_byte_budget
    import lcb_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lcb_req_if.sink                    req,
    lcb_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcb_dp #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_data  (req.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );

endmodule

`default_nettype wire

FILE: src/lcb_checker.sv
// Port-level checks for the byte-budget LRU cache, bound to the top level.
// Depends on lcb_pkg for the result type.
`default_nettype none

module lcb_checker
    import lcb_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_data
);

    // A stalled result stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // A lookup hit never reports evictions.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.hit |-> rsp_data.evicted == 5'd0)
        else $error("hit reported with evictions");

    // A hit means the cache holds at least one entry.
    a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.hit |-> rsp_data.entries_held != 5'd0)
        else $error("hit reported on empty cache");

    // The cache never holds more entries than it has slots.
    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_data.entries_held) <= 32'(SLOTS))
        else $error("entry count above slot count");

    // A request transfer is followed by a busy cycle.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

endmodule

bind lru_cache_byte_budget lcb_checker #(.SLOTS(SLOTS)) u_lcb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the byte-budget LRU cache (lru_cache_byte_budget).
// Depends on lcb_pkg, lcb_req_if, lcb_rsp_if and the cache RTL; it reads no files.
`timescale 1ns / 100ps

module testbench;
    import lcb_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam logic [39:0] TOTAL_TOP = 40'hFF_FFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcb_req_if req_ch();
    lcb_rsp_if rsp_ch();

    lru_cache_byte_budget DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow of the cache contents, most recent entry first.
    logic [63:0] lru_tags[$];
    logic [31:0] lru_sizes[$];
    logic [39:0] bytes_total;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] limit_reg;
    logic [31:0] floor_reg;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic [63:0] key_pool[$];

    int mismatches;
    int cycle_count;
    int send_gap;
    int stall_gap;
    bit quiet;
    logic req_took;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void drop_oldest();
        logic [31:0] sz;
        sz = lru_sizes[lru_sizes.size()-1];
        bytes_total = (bytes_total > {8'd0, sz}) ? bytes_total - {8'd0, sz} : 40'd0;
        void'(lru_tags.pop_back());
        void'(lru_sizes.pop_back());
    endfunction

    function automatic rsp_t cache_apply(req_t r);
        rsp_t res;
        logic [40:0] sum;
        logic [63:0] tg;
        logic [31:0] sz;
        int ev;
        bit found;
        ev = 0;
        found = 0;
        res = '0;
        if (r.mode == 1'b0) begin
            for (int i = 0; i < lru_tags.size(); i++) begin
                if (!found && lru_tags[i] == r.key) begin
                    found = 1;
                    tg = lru_tags[i];
                    sz = lru_sizes[i];
                    lru_tags.delete(i);
                    lru_sizes.delete(i);
                    lru_tags.push_front(tg);
                    lru_sizes.push_front(sz);
                end
            end
            if (found)
                hit_count++;
            else
                miss_count++;
        end
        else begin
            sum = {1'b0, bytes_total} + {9'd0, r.item_bytes};
            bytes_total = sum[40] ? TOTAL_TOP : sum[39:0];
            if (limit_reg != 0 && {8'd0, limit_reg} <= bytes_total && lru_tags.size() > 0) begin
                do begin
                    drop_oldest();
                    ev++;
                end while (lru_tags.size() > 0 && {8'd0, floor_reg} < bytes_total);
            end
            if (lru_tags.size() >= SLOT_COUNT) begin
                drop_oldest();
                ev++;
            end
            lru_tags.push_front(r.key);
            lru_sizes.push_front(r.item_bytes);
        end
        res.hit = found;
        res.evicted = ev[4:0];
        res.bytes_held = bytes_total;
        res.entries_held = 5'(lru_tags.size());
        res.hit_total = hit_count;
        res.miss_total = miss_count;
        return res;
    endfunction

    // Checker and predictor; the response check runs first since a result
    // leaving at an edge always belongs to an older request.
    always @(posedge clk)
    begin
        rsp_t want;
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
        else if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", rsp_ch.data);
                end
                else begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.data.hit !== want.hit
                        || rsp_ch.data.evicted !== want.evicted
                        || rsp_ch.data.bytes_held !== want.bytes_held
                        || rsp_ch.data.entries_held !== want.entries_held
                        || rsp_ch.data.hit_total !== want.hit_total
                        || rsp_ch.data.miss_total !== want.miss_total) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p", want, rsp_ch.data);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(cache_apply(req_ch.data));
        end
        req_took <= req_ch.valid && req_ch.ready;
    end

    // Request driver: holds an item until its transfer, inserts idle bursts.
    always @(negedge clk)
    begin
        if (req_ch.valid && !req_took) begin
            req_ch.valid <= 1'b1;
        end
        else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
        end
        else if (pending_reqs.size() > 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 18) - 1;
                req_ch.valid <= 1'b0;
            end
            else begin
                req_ch.data <= pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
            end
        end
        else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Result receiver with random stall bursts.
    always @(negedge clk)
    begin
        if (stall_gap > 0) begin
            stall_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_gap = $urandom_range(1, 18) - 1;
            rsp_ch.ready <= 1'b0;
        end
        else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_BYTE_LIMIT)
            limit_reg = val;
        else
            floor_reg = val;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic queue_op(input logic mode, input logic [63:0] key, input logic [31:0] nbytes);
        req_t r;
        r.mode = mode;
        r.key = key;
        r.item_bytes = nbytes;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int count, input int size_top);
        logic [63:0] key;
        logic [31:0] nbytes;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                key = {$urandom, $urandom};
            else
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if ($urandom_range(0, 7) == 0)
                nbytes = $urandom;
            else
                nbytes = $urandom_range(0, size_top);
            queue_op(1'($urandom_range(0, 1)), key, nbytes);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        req_took = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        send_gap = 0;
        stall_gap = 0;
        quiet = 0;
        bytes_total = '0;
        hit_count = '0;
        miss_count = '0;
        limit_reg = '0;
        floor_reg = '0;
        key_pool.push_back(64'd0);
        key_pool.push_back('1);
        for (int i = 0; i < 22; i++)
            key_pool.push_back({$urandom, $urandom});
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty lookup, extremes, duplicates, then overfill all slots.
        write_reg(REG_BYTE_LIMIT, 32'd0);
        write_reg(REG_EVICT_FLOOR, 32'd0);
        queue_op(1'b0, 64'd0, 32'd0);
        queue_op(1'b1, 64'd0, 32'd0);
        queue_op(1'b1, '1, '1);
        queue_op(1'b1, 64'd0, 32'd5);
        queue_op(1'b0, 64'd0, '1);
        queue_op(1'b0, '1, 32'd0);
        queue_op(1'b0, 64'h1234, 32'd0);
        for (int i = 0; i < 15; i++)
            queue_op(1'b1, 64'h100 + i, '1);
        queue_op(1'b0, '1, 32'd0);
        queue_op(1'b0, 64'h100, 32'd0);
        wait_drained();

        // Limit of one, top floor: a register evicts from the back down to the floor.
        write_reg(REG_BYTE_LIMIT, 32'd1);
        write_reg(REG_EVICT_FLOOR, '1);
        queue_random(150, 100);
        wait_drained();

        write_reg(REG_BYTE_LIMIT, 32'd4000);
        write_reg(REG_EVICT_FLOOR, 32'd1000);
        queue_random(400, 1500);
        wait_drained();

        write_reg(REG_BYTE_LIMIT, '1);
        write_reg(REG_EVICT_FLOOR, '1);
        queue_random(300, 3000);
        wait_drained();

        write_reg(REG_BYTE_LIMIT, '1);
        write_reg(REG_EVICT_FLOOR, 32'd0);
        queue_random(250, 32'h7FFF_FFFF);
        wait_drained();

        write_reg(REG_BYTE_LIMIT, 32'd20000);
        write_reg(REG_EVICT_FLOOR, 32'd15000);
        queue_random(300, 4000);
        wait_drained();

        quiet = 1;
        write_reg(REG_BYTE_LIMIT, 32'd0);
        write_reg(REG_EVICT_FLOOR, 32'd0);
        queue_random(250, 5000);
        wait_drained();

        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
